// ----- rtl/bcpf_pkg.sv -----
`default_nettype none
package bcpf_pkg;

    // Register indexes on the configuration port (word address = 4 * index)
    localparam logic [1:0] REG_BASELINE  = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_INVERT    = 2'd2;

    // Segment tracking modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ABOVE = 2'd1;
    localparam logic [1:0] MODE_BELOW = 2'd2;

    // Result field widths and saturation limits
    localparam int IDX_W  = 16;
    localparam int EXT_W  = 17;
    localparam int AREA_W = 33;
    localparam int EXT_MAX = 65535;
    localparam int EXT_MIN = -65536;

    typedef struct packed {
        logic [IDX_W-1:0]         seg_start;
        logic [IDX_W-1:0]         seg_end;
        logic                     polarity;
        logic                     qualified;
        logic signed [EXT_W-1:0]  extreme_dev;
        logic signed [AREA_W-1:0] area;
    } seg_result_t;

endpackage
`default_nettype wire

// ----- rtl/baseline_crossing_pulse_finder_unit.sv -----
// The closing sample word passes the input register, then its result is registered.
// Throughput: one sample word per cycle; the input register and the result register
// advance together and stall only while a result waits on m_tready.
// Reset (rst_n low, asynchronous): registers return to baseline 0, threshold 0,
// no inversion; tracking goes idle, sample index 0, both stages empty.
`default_nettype none
module baseline_crossing_pulse_finder_unit
    import bcpf_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int RECORD_LENGTH = 65536
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // sample stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample
    input  wire logic                s_tlast,              // last_sample
    // segment results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [87:0]              m_tdata,  // seg_start, seg_end, extreme_dev, area
    output logic [1:0]               m_tuser   // polarity, qualified
);

    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DW   = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
    localparam int IW   = $clog2(RECORD_LENGTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(RECORD_LENGTH - 1);
    localparam logic signed [DW-1:0] EXT_HI = DW'(EXT_MAX);
    localparam logic signed [DW-1:0] EXT_LO = DW'(EXT_MIN);

    // configuration registers
    logic signed [15:0] baseline_reg;
    logic [14:0]        threshold_reg;
    logic               invert_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            threshold_reg <= '0;
            invert_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_BASELINE:  baseline_reg  <= pwdata[15:0];
                REG_THRESHOLD: threshold_reg <= pwdata[14:0];
                REG_INVERT:    invert_reg    <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_BASELINE:  prdata = {{16{baseline_reg[15]}}, baseline_reg};
            REG_THRESHOLD: prdata = {17'b0, threshold_reg};
            REG_INVERT:    prdata = {31'b0, invert_reg};
            default:       prdata = '0;
        endcase
    end

    // handshake: both stages move when the result register is free
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // deviation of the incoming word from baseline
    logic signed [DW-1:0] s_ext;
    logic signed [DW-1:0] s_pol;
    logic signed [DW-1:0] dev_in;
    logic [IN_W-1:0]      s_unused;

    assign s_unused = s_tdata;
    assign s_ext  = {{(DW-SAMPLE_BITS){s_unused[SAMPLE_BITS-1]}}, s_unused[SAMPLE_BITS-1:0]};
    assign s_pol  = invert_reg ? -s_ext : s_ext;
    assign dev_in = s_pol - {{(DW-16){baseline_reg[15]}}, baseline_reg};

    // input register
    logic signed [DW-1:0] dev_reg;
    logic                 last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            dev_reg  <= dev_in;
            last_reg <= s_tlast;
        end
    end

    // segment state
    logic [1:0]               mode_reg,   mode_next;
    logic [IW-1:0]            idx_reg,    idx_next;
    logic [IW-1:0]            start_reg,  start_next;
    logic                     passed_reg, passed_next;
    logic signed [EXT_W-1:0]  ext_reg,    ext_next;
    logic signed [AREA_W-1:0] area_reg,   area_next;
    seg_result_t              res_reg,    res_next;
    logic                     out_valid_next;

    logic signed [DW-1:0]     th_ext;
    logic signed [DW-1:0]     dev_clamp;
    logic signed [EXT_W-1:0]  dev_c;
    logic signed [AREA_W:0]   area_sum;
    logic signed [AREA_W-1:0] area_sat;
    logic signed [AREA_W-1:0] dev_area;
    logic                     over_hi;
    logic                     under_lo;
    logic                     closes;
    logic [IW+IDX_W-1:0]      idx_wide;
    logic [IW+IDX_W-1:0]      start_wide;

    assign th_ext    = {{(DW-15){1'b0}}, threshold_reg};
    assign over_hi   = dev_reg > th_ext;
    assign under_lo  = dev_reg < -th_ext;
    assign dev_clamp = (dev_reg > EXT_HI) ? EXT_HI : ((dev_reg < EXT_LO) ? EXT_LO : dev_reg);
    assign dev_c     = dev_clamp[EXT_W-1:0];
    assign dev_area  = {{(AREA_W-DW){dev_reg[DW-1]}}, dev_reg};
    assign area_sum  = {area_reg[AREA_W-1], area_reg} + {dev_area[AREA_W-1], dev_area};
    assign idx_wide   = {{IDX_W{1'b0}}, idx_reg};
    assign start_wide = {{IDX_W{1'b0}}, start_reg};

    // saturate the running area to its own width
    always_comb
    begin
        if (area_sum[AREA_W] != area_sum[AREA_W-1])
        begin
            area_sat = area_sum[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}}
                                        : {1'b0, {(AREA_W-1){1'b1}}};
        end
        else
        begin
            area_sat = area_sum[AREA_W-1:0];
        end
    end

    assign closes = ((mode_reg == MODE_ABOVE) && dev_reg[DW-1]) ||
                    ((mode_reg == MODE_BELOW) && !dev_reg[DW-1] && (dev_reg != '0));

    // track, extend or close the segment for the word in the input register
    always_comb
    begin
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        passed_next    = passed_reg;
        ext_next       = ext_reg;
        area_next      = area_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (in_valid_reg && advance)
        begin
            out_valid_next = 1'b0;
            case (mode_reg)
                MODE_ABOVE, MODE_BELOW:
                begin
                    if (closes)
                    begin
                        out_valid_next       = 1'b1;
                        res_next.seg_start   = start_wide[IDX_W-1:0];
                        res_next.seg_end     = idx_wide[IDX_W-1:0];
                        res_next.polarity    = (mode_reg == MODE_BELOW);
                        res_next.qualified   = passed_reg;
                        res_next.extreme_dev = ext_reg;
                        res_next.area        = area_reg;
                        mode_next   = MODE_IDLE;
                        start_next  = '0;
                        passed_next = 1'b0;
                        ext_next    = '0;
                        area_next   = '0;
                    end
                    else
                    begin
                        area_next = area_sat;
                        if (mode_reg == MODE_ABOVE)
                        begin
                            if (dev_c > ext_reg) ext_next = dev_c;
                            if (over_hi) passed_next = 1'b1;
                        end
                        else
                        begin
                            if (dev_c < ext_reg) ext_next = dev_c;
                            if (under_lo) passed_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (!last_reg && (dev_reg != '0))
                    begin
                        mode_next   = dev_reg[DW-1] ? MODE_BELOW : MODE_ABOVE;
                        start_next  = idx_reg;
                        ext_next    = dev_c;
                        area_next   = dev_area;
                        passed_next = dev_reg[DW-1] ? under_lo : over_hi;
                    end
                end
            endcase

            // end of record drops any open segment
            if (last_reg)
            begin
                mode_next   = MODE_IDLE;
                start_next  = '0;
                passed_next = 1'b0;
                ext_next    = '0;
                area_next   = '0;
                idx_next    = '0;
            end
            else
            begin
                idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            idx_reg       <= '0;
            start_reg     <= '0;
            passed_reg    <= 1'b0;
            ext_reg       <= '0;
            area_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            passed_reg    <= passed_next;
            ext_reg       <= ext_next;
            area_reg      <= area_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res_reg.area, res_reg.extreme_dev, res_reg.seg_end,
                       res_reg.seg_start};
    assign m_tuser  = {res_reg.qualified, res_reg.polarity};

    // a word processed while idle never yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && (mode_reg == MODE_IDLE) |=> !out_valid_reg)
        else $error("result produced from idle mode");

    // end of record resets tracking
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && last_reg |=> (mode_reg == MODE_IDLE) && (idx_reg == '0))
        else $error("record end did not clear tracking");

    // extreme sign follows polarity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.polarity == res_reg.extreme_dev[EXT_W-1]))
        else $error("extreme deviation sign disagrees with polarity");

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with free result register");

endmodule
`default_nettype wire
